// File: hw/rtl/mbps_pkg.sv
// Package for the masked byte pattern search: widths, register map codes,
// result and cell control types. No dependencies; used by every other file.

package mbps_pkg;

   // payload and register widths
   localparam int BYTE_W     = 8;
   localparam int POS_W      = 17;
   localparam int PAT_BYTES  = 16;
   localparam int PAT_W      = 64;
   localparam int MASK_W     = 16;
   localparam int LEN_W      = 5;
   localparam int OFFSET_W   = 16;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_IDX_W  = 3;

   // register indexes, one per 64-bit slot of the register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LOW    = 3'd0,
      CSR_PATTERN_HIGH   = 3'd1,
      CSR_CARE_MASK      = 3'd2,
      CSR_PATTERN_LENGTH = 3'd3,
      CSR_RESULT_OFFSET  = 3'd4
   } csr_reg_type;

   // one result item
   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] base_position;
   } rsp_item_type;

   // control broadcast to every window cell
   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

endpackage

// File: hw/rtl/mbps_if.sv
// Valid/ready channel interfaces of the masked byte pattern search.
// Depends on mbps_pkg for the payload widths.

interface mbps_req_if;
   logic                       valid;
   logic                       ready;
   logic [mbps_pkg::BYTE_W-1:0] data_byte;
   logic                       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mbps_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      found;
   logic [mbps_pkg::POS_W-1:0] base_position;

   modport source (output valid, output found, output base_position, input ready);
   modport sink   (input valid, input found, input base_position, output ready);
endinterface

// File: hw/rtl/mbps_cell.sv
// One window cell: holds one buffer byte, hands it on to the next cell and
// compares the byte entering it against its aligned pattern byte. Uses mbps_pkg.

module mbps_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  mbps_pkg::cell_ctrl_type      ctrl,
   input  logic [mbps_pkg::BYTE_W-1:0]  shift_byte,
   input  logic [mbps_pkg::BYTE_W-1:0]  pat_byte,
   input  logic                         care,
   output logic [mbps_pkg::BYTE_W-1:0]  out_byte,
   output logic                         hit
);

   logic [mbps_pkg::BYTE_W-1:0] byte_ff;
   logic [mbps_pkg::BYTE_W-1:0] byte_in;

   // drop the byte at buffer end, take the neighbour's byte on a shift, else hold
   always_comb begin
      if (ctrl.clear) begin
         byte_in = '0;
      end else if (ctrl.shift) begin
         byte_in = shift_byte;
      end else begin
         byte_in = byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= '0;
      end else begin
         byte_ff <= byte_in;
      end
   end

   // compare the byte this cell will hold after the shift
   assign hit      = !care || (shift_byte == pat_byte);
   assign out_byte = byte_ff;

endmodule

// File: hw/rtl/mbps_rsp_queue.sv
// Two-entry result queue that drives the result channel, so the scan keeps
// taking bytes while a result waits. Uses mbps_pkg and mbps_rsp_if.

module mbps_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  mbps_pkg::rsp_item_type push_item,
   output logic                   space,
   mbps_rsp_if.source             rsp
);

   mbps_pkg::rsp_item_type entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       pop;

   assign pop   = rsp.valid && rsp.ready;
   assign space = (count_ff != 2'd2);

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed result
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   // present the oldest result
   assign rsp.valid         = (count_ff != 2'd0);
   assign rsp.found         = entry_ff[rd_ptr_ff].found;
   assign rsp.base_position = entry_ff[rd_ptr_ff].base_position;

   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 |-> !push)
      else $error("result pushed into a full queue");

   a_count_in_range : assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result queue occupancy out of range");

   a_pop_drains : assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - 2'd1)
      else $error("result queue occupancy did not drop on a transfer out");

endmodule

// File: hw/rtl/masked_byte_pattern_search.sv
// Top level of the masked byte pattern search: register block, window cell
// chain, match decision and result queue. Uses mbps_pkg, mbps_if, mbps_cell,
// mbps_rsp_queue.
//
//   Channel  Dir   Handshake          Payload
//   req      in    valid/ready        data_byte[7:0], last_byte
//   rsp      out   valid/ready        found, base_position[16:0]
//   csr      in    APB psel/penable   paddr[5:3] register, pwdata[63:0]
//
// One byte is taken per cycle while the queue has space; its result, if any, is
// pushed into the result queue at the same edge and shows on rsp once older results are taken.
// The window compare is combinational across all cells, so the sustained
// rate is one byte per clock while rsp keeps up.
// req.ready drops only while two results wait in the queue.
// Reset (synchronous) clears the window, the byte count, the match flag and
// the queue, and sets the registers to their reset values.

module masked_byte_pattern_search #(
   parameter int              MAX_PATTERN = 16,
   parameter longint unsigned MAX_BUFFER  = 65536
) (
   input  logic                              clock,
   input  logic                              reset,
   mbps_req_if.sink                          req,
   mbps_rsp_if.source                        rsp,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mbps_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [mbps_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [mbps_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   localparam int CW    = $clog2(MAX_BUFFER + 64'd1);
   localparam int PBW   = mbps_pkg::PAT_BYTES * mbps_pkg::BYTE_W;

   // configuration registers
   logic [mbps_pkg::PAT_W-1:0]    pattern_low_ff;
   logic [mbps_pkg::PAT_W-1:0]    pattern_high_ff;
   logic [mbps_pkg::MASK_W-1:0]   care_mask_ff;
   logic [mbps_pkg::LEN_W-1:0]    pattern_length_ff;
   logic [mbps_pkg::OFFSET_W-1:0] result_offset_ff;

   mbps_pkg::csr_reg_type csr_reg;
   logic                  csr_write;

   assign csr_reg    = mbps_pkg::csr_reg_type'(csr_paddr[mbps_pkg::CSR_ADDR_W-1:3]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   // write the addressed register, ignore unmapped slots
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         care_mask_ff      <= '1;
         pattern_length_ff <= mbps_pkg::LEN_W'(1);
         result_offset_ff  <= '0;
      end else if (csr_write) begin
         case (csr_reg)
            mbps_pkg::CSR_PATTERN_LOW: begin
               pattern_low_ff <= csr_pwdata;
            end
            mbps_pkg::CSR_PATTERN_HIGH: begin
               pattern_high_ff <= csr_pwdata;
            end
            mbps_pkg::CSR_CARE_MASK: begin
               care_mask_ff <= csr_pwdata[mbps_pkg::MASK_W-1:0];
            end
            mbps_pkg::CSR_PATTERN_LENGTH: begin
               pattern_length_ff <= csr_pwdata[mbps_pkg::LEN_W-1:0];
            end
            mbps_pkg::CSR_RESULT_OFFSET: begin
               result_offset_ff <= csr_pwdata[mbps_pkg::OFFSET_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // read back the addressed register
   always_comb begin
      case (csr_reg)
         mbps_pkg::CSR_PATTERN_LOW:    csr_prdata = pattern_low_ff;
         mbps_pkg::CSR_PATTERN_HIGH:   csr_prdata = pattern_high_ff;
         mbps_pkg::CSR_CARE_MASK:      csr_prdata = mbps_pkg::CSR_DATA_W'(care_mask_ff);
         mbps_pkg::CSR_PATTERN_LENGTH: csr_prdata = mbps_pkg::CSR_DATA_W'(pattern_length_ff);
         mbps_pkg::CSR_RESULT_OFFSET:  csr_prdata = mbps_pkg::CSR_DATA_W'(result_offset_ff);
         default:                      csr_prdata = '0;
      endcase
   end

   // clamp the pattern length to 1..MAX_PATTERN
   logic [mbps_pkg::LEN_W-1:0] used_len;

   always_comb begin
      if (pattern_length_ff == '0) begin
         used_len = mbps_pkg::LEN_W'(1);
      end else if (pattern_length_ff > mbps_pkg::LEN_W'(MAX_PATTERN)) begin
         used_len = mbps_pkg::LEN_W'(MAX_PATTERN);
      end else begin
         used_len = pattern_length_ff;
      end
   end

   // align the pattern to the window: cell k (age k) meets pattern byte len-1-k.
   // Reverse the byte order, then shift down by 16-len; cells past len see no care.
   logic [PBW-1:0]                 pat_all;
   logic [PBW-1:0]                 rev_pat;
   logic [mbps_pkg::MASK_W-1:0]    rev_care;
   logic [mbps_pkg::LEN_W-1:0]     align_shift;
   logic [PBW-1:0]                 aligned_pat;
   logic [mbps_pkg::MASK_W-1:0]    aligned_care;

   assign pat_all     = {pattern_high_ff, pattern_low_ff};
   assign align_shift = mbps_pkg::LEN_W'(mbps_pkg::PAT_BYTES) - used_len;

   for (genvar j = 0; j < mbps_pkg::PAT_BYTES; j++) begin : g_rev
      assign rev_pat[mbps_pkg::BYTE_W*j +: mbps_pkg::BYTE_W] =
         pat_all[mbps_pkg::BYTE_W*(mbps_pkg::PAT_BYTES-1-j) +: mbps_pkg::BYTE_W];
      assign rev_care[j] = care_mask_ff[mbps_pkg::PAT_BYTES-1-j];
   end

   assign aligned_pat  = rev_pat >> {align_shift, 3'b000};
   assign aligned_care = rev_care >> align_shift;

   // buffer progress
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [CW-1:0] count_inc;
   logic          match_done_ff;
   logic          match_done_in;
   logic          accept;
   logic          room;

   mbps_pkg::cell_ctrl_type cell_ctrl;

   assign accept    = req.valid && req.ready;
   assign room      = (count_ff < CW'(MAX_BUFFER));
   assign count_inc = count_ff + CW'(1);

   assign cell_ctrl.shift = accept && room;
   assign cell_ctrl.clear = accept && req.last_byte;

   // window cell chain
   logic [mbps_pkg::BYTE_W-1:0] cell_byte [MAX_PATTERN];
   logic [MAX_PATTERN-1:0]      cell_hit;

   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
      logic [mbps_pkg::BYTE_W-1:0] feed;

      if (k == 0) begin : g_head
         assign feed = req.data_byte;
      end else begin : g_link
         assign feed = cell_byte[k-1];
      end

      mbps_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .shift_byte (feed),
         .pat_byte   (aligned_pat[mbps_pkg::BYTE_W*k +: mbps_pkg::BYTE_W]),
         .care       (aligned_care[k]),
         .out_byte   (cell_byte[k]),
         .hit        (cell_hit[k])
      );
   end

   // decide on a match for the byte being taken
   logic                   found_now;
   logic                   miss_end;
   logic [CW-1:0]          start_pos;
   logic [mbps_pkg::POS_W-1:0] base_pos;

   assign found_now = cell_ctrl.shift && !match_done_ff && (&cell_hit) &&
                      (count_inc >= CW'(used_len));
   assign miss_end  = cell_ctrl.clear && !match_done_ff && !found_now;
   assign start_pos = count_inc - CW'(used_len);
   assign base_pos  = mbps_pkg::POS_W'(start_pos) + mbps_pkg::POS_W'(result_offset_ff);

   // advance the count, latch the match, drop both at buffer end
   always_comb begin
      count_in      = count_ff;
      match_done_in = match_done_ff;
      if (cell_ctrl.clear) begin
         count_in      = '0;
         match_done_in = 1'b0;
      end else begin
         if (cell_ctrl.shift) begin
            count_in = count_inc;
         end
         if (found_now) begin
            match_done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         match_done_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         match_done_ff <= match_done_in;
      end
   end

   // result queue
   logic                   push;
   logic                   space;
   mbps_pkg::rsp_item_type push_item;

   assign push                    = found_now || miss_end;
   assign push_item.found         = found_now;
   assign push_item.base_position = found_now ? base_pos : '0;

   mbps_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .space     (space),
      .rsp       (rsp)
   );

   assign req.ready = space;

   a_push_from_transfer : assert property (@(posedge clock) disable iff (reset)
      push |-> accept)
      else $error("result pushed without an input transfer");

   a_end_clears : assert property (@(posedge clock) disable iff (reset)
      accept && req.last_byte |=> count_ff == '0 && !match_done_ff)
      else $error("buffer state not cleared after the last byte");

   a_miss_only_at_end : assert property (@(posedge clock) disable iff (reset)
      push && !found_now |-> req.last_byte && !match_done_ff)
      else $error("not-found result away from the buffer end");

   a_single_match : assert property (@(posedge clock) disable iff (reset)
      match_done_ff |-> !found_now)
      else $error("second match reported in one buffer");

endmodule

// File: sim/mbps_search_checker.sv
// Checker for the masked byte pattern search: follows register writes, predicts
// the result of every byte transfer and compares it with the result channel.
// Depends on mbps_pkg and the channel interfaces in mbps_if.

module mbps_search_checker import mbps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   mbps_req_if                   req,
   mbps_rsp_if                   rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output int                    pending,
   output int                    failures
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          WINDOW_DEPTH = PAT_BYTES;
   localparam int unsigned SCAN_LIMIT   = 65536;

   // register copy
   logic [2*PAT_W-1:0]    pattern_bytes;
   logic [MASK_W-1:0]     care_bits;
   logic [LEN_W-1:0]      length_reg;
   logic [OFFSET_W-1:0]   offset_reg;

   // scan state of the open buffer
   logic [BYTE_W-1:0]     window [WINDOW_DEPTH];
   int unsigned           seen_count;
   logic                  matched;

   rsp_item_type          awaited_results [$];
   int                    errors = 0;

   function automatic void clear_scan();
      for (int k = 0; k < WINDOW_DEPTH; k++) window[k] = '0;
      seen_count = 0;
      matched    = 1'b0;
   endfunction

   // newest window entry lines up with the last pattern byte in use
   function automatic logic window_hit(int unsigned len);
      for (int j = 0; j < len; j++) begin
         if (care_bits[j] && window[len-1-j] != pattern_bytes[8*j +: 8]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // advance the scan by one byte and queue the result it causes, if any
   function automatic void scan_byte(logic [BYTE_W-1:0] data, logic closes);
      int unsigned  len;
      logic         emitted;
      rsp_item_type item;
      emitted = 1'b0;
      if (seen_count < SCAN_LIMIT) begin
         len = (length_reg == 0) ? 1 : (length_reg > WINDOW_DEPTH) ? WINDOW_DEPTH : length_reg;
         for (int k = WINDOW_DEPTH - 1; k > 0; k--) window[k] = window[k-1];
         window[0] = data;
         seen_count++;
         if (!matched && seen_count >= len && window_hit(len)) begin
            item.found         = 1'b1;
            item.base_position = POS_W'(seen_count - len + offset_reg);
            awaited_results.push_back(item);
            matched = 1'b1;
            emitted = 1'b1;
         end
      end
      if (closes) begin
         if (!emitted && !matched) begin
            item = '0;
            awaited_results.push_back(item);
         end
         clear_scan();
      end
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         pattern_bytes = '0;
         care_bits     = '1;
         length_reg    = LEN_W'(1);
         offset_reg    = '0;
         clear_scan();
         awaited_results.delete();
      end else begin
         // apply a register write; unmapped slots are dropped
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_W-1:3])
               CSR_PATTERN_LOW:    pattern_bytes[PAT_W-1:0]       = csr_pwdata[PAT_W-1:0];
               CSR_PATTERN_HIGH:   pattern_bytes[2*PAT_W-1:PAT_W] = csr_pwdata[PAT_W-1:0];
               CSR_CARE_MASK:      care_bits  = csr_pwdata[MASK_W-1:0];
               CSR_PATTERN_LENGTH: length_reg = csr_pwdata[LEN_W-1:0];
               CSR_RESULT_OFFSET:  offset_reg = csr_pwdata[OFFSET_W-1:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) scan_byte(req.data_byte, req.last_byte);
         // compare each result transfer with the oldest prediction
         if (rsp.valid && rsp.ready) begin
            if (awaited_results.size() == 0) begin
               $error("unexpected result: found=%0d base_position=%0d",
                      rsp.found, rsp.base_position);
               errors++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp.found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, rsp.found);
                  errors++;
               end
               if (rsp.base_position !== want.base_position) begin
                  $error("base_position: expected %0d, got %0d",
                         want.base_position, rsp.base_position);
                  errors++;
               end
            end
         end
      end
      pending  <= awaited_results.size();
      failures <= errors;
   end

endmodule

// File: sim/tb_masked_byte_pattern_search.sv
// Testbench top for the masked byte pattern search: clock, reset, register
// writes and byte streams under several idling phases, then the verdict.
// Depends on mbps_pkg, mbps_if, the RTL top and mbps_search_checker.

module tb_masked_byte_pattern_search;
   timeunit 1ns;
   timeprecision 1ps;
   import mbps_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_FIRST = 3'd5;
   localparam logic [BYTE_W-1:0]    CHAR_X        = 8'h78;
   localparam logic [BYTE_W-1:0]    CHAR_Q        = 8'h3F;
   localparam int                   QUIET_LIMIT   = 5000;
   localparam int                   SETTLE_CYCLES = 4;
   localparam int                   PHASE_ITEMS   = 45;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int                    pending;
   int                    failures;
   int                    quiet_cycles = 0;
   int                    send_gap_pct = 0;
   int                    stall_pct    = 0;
   int                    bytes_sent   = 0;

   // pattern as last written, used to build matching streams
   logic [BYTE_W-1:0]     pat [PAT_BYTES];
   logic [MASK_W-1:0]     care_sel;
   int unsigned           used_len;
   logic [BYTE_W-1:0]     stream [$];

   mbps_req_if req_ch ();
   mbps_rsp_if rsp_ch ();

   masked_byte_pattern_search u_top (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   mbps_search_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .pending     (pending),
      .failures    (failures)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // result side: stall at the rate of the current phase
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   // end the run when nothing has been transferred for too long
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // setup then access phase; psel stays high across back-to-back writes
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   // write every register, junk in the unused upper bits, plus one unmapped slot
   task automatic set_config(input logic [PAT_W-1:0] lo, input logic [PAT_W-1:0] hi,
                             input logic [MASK_W-1:0] care, input logic [LEN_W-1:0] len,
                             input logic [OFFSET_W-1:0] offset);
      logic [CSR_DATA_W-1:0] junk;
      junk = {$urandom, $urandom};
      write_reg(CSR_PATTERN_LOW, lo);
      write_reg(CSR_UNMAPPED_FIRST + CSR_IDX_W'($urandom_range(2)), junk);
      write_reg(CSR_PATTERN_HIGH, hi);
      write_reg(CSR_CARE_MASK, {junk[CSR_DATA_W-1:MASK_W], care});
      write_reg(CSR_PATTERN_LENGTH, {junk[CSR_DATA_W-1:LEN_W], len});
      write_reg(CSR_RESULT_OFFSET, {junk[CSR_DATA_W-1:OFFSET_W], offset});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      for (int k = 0; k < 8; k++) begin
         pat[k]   = lo[8*k +: 8];
         pat[k+8] = hi[8*k +: 8];
      end
      care_sel = care;
      used_len = (len == 0) ? 1 : (len > PAT_BYTES) ? PAT_BYTES : len;
   endtask

   // hold valid across items unless a gap is drawn
   task automatic send_byte(input logic [BYTE_W-1:0] value, input logic closes);
      if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
         req_ch.valid     <= 1'b0;
         req_ch.data_byte <= BYTE_W'($urandom);
         req_ch.last_byte <= 1'($urandom);
         @(posedge clock);
         while ($urandom_range(99) < send_gap_pct) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= value;
      req_ch.last_byte <= closes;
      do @(posedge clock); while (!req_ch.ready);
      bytes_sent++;
   endtask

   task automatic send_stream();
      for (int i = 0; i < stream.size(); i++) send_byte(stream[i], i == stream.size() - 1);
   endtask

   // drop valid, wait for every predicted result, then let the pipeline settle
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_config();
      logic [PAT_W-1:0]    lo;
      logic [PAT_W-1:0]    hi;
      logic [MASK_W-1:0]   care;
      logic [LEN_W-1:0]    len;
      logic [OFFSET_W-1:0] offset;
      int unsigned         pick;
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      // a two-letter alphabet gives self-overlapping patterns
      if ($urandom_range(1)) begin
         for (int k = 0; k < 8; k++) begin
            lo[8*k +: 8] = $urandom_range(1) ? CHAR_X : CHAR_Q;
            hi[8*k +: 8] = $urandom_range(1) ? CHAR_X : CHAR_Q;
         end
      end
      pick = $urandom_range(99);
      care = (pick < 40) ? '1 : (pick < 45) ? '0 : MASK_W'($urandom);
      pick = $urandom_range(99);
      len  = (pick < 10) ? '0 : (pick < 20) ? LEN_W'($urandom_range(31, 17))
                                            : LEN_W'($urandom_range(16, 1));
      pick = $urandom_range(99);
      offset = (pick < 20) ? '0 : (pick < 40) ? '1 : OFFSET_W'($urandom);
      set_config(lo, hi, care, len, offset);
   endtask

   // mostly pattern-alphabet streams with the pattern planted, some near misses, some noise
   task automatic send_random_buffer();
      int unsigned size;
      int unsigned kind;
      int unsigned start;
      stream.delete();
      size = ($urandom_range(9) == 0) ? $urandom_range(120, 41) : $urandom_range(40, 1);
      kind = $urandom_range(99);
      for (int i = 0; i < size; i++) begin
         if (kind < 85 && $urandom_range(1)) stream.push_back(pat[$urandom_range(used_len - 1)]);
         else stream.push_back(BYTE_W'($urandom));
      end
      if (kind < 65 && size >= used_len) begin
         start = $urandom_range(size - used_len);
         for (int j = 0; j < used_len; j++) begin
            if (care_sel[j]) stream[start + j] = pat[j];
         end
      end
      send_stream();
   endtask

   initial begin
      int phase_start;
      req_ch.valid     <= 1'b0;
      req_ch.data_byte <= '0;
      req_ch.last_byte <= 1'b0;
      csr_psel         <= 1'b0;
      csr_penable      <= 1'b0;
      csr_pwrite       <= 1'b0;
      csr_paddr        <= '0;
      csr_pwdata       <= '0;
      reset            <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset registers: a zero byte matches at once, later bytes are ignored
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      drain();

      // overlapping candidate completing on the last byte, then a short buffer
      set_config({40'h0, CHAR_Q, CHAR_X, CHAR_X}, '1, '1, 5'd3, 16'h0010);
      send_byte(CHAR_X, 1'b0);
      send_byte(CHAR_X, 1'b0);
      send_byte(CHAR_X, 1'b0);
      send_byte(CHAR_Q, 1'b1);
      send_byte(CHAR_X, 1'b0);
      send_byte(CHAR_X, 1'b1);
      drain();

      // wildcard in the middle of the pattern
      set_config({40'h0, CHAR_Q, CHAR_X, CHAR_X}, '1, 16'hFFFD, 5'd3, 16'h0010);
      send_byte(CHAR_X, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(CHAR_Q, 1'b1);
      drain();

      // length zero acts as one, all wildcards, largest offset
      set_config({40'h0, CHAR_Q, CHAR_X, CHAR_X}, '1, '0, 5'd0, '1);
      send_byte(8'h5A, 1'b1);
      drain();

      // length above the maximum acts as sixteen
      set_config(64'h00FF_00FF_00FF_00FF, 64'hFF00_FF00_FF00_FF00, '1, 5'd31, '1);
      for (int j = 0; j < PAT_BYTES; j++) send_byte(pat[j], j == PAT_BYTES - 1);
      drain();

      // random phases: none, sender idle, receiver stalls, both
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 87; stall_pct = 0;  end
            2: begin send_gap_pct = 0;  stall_pct = 87; end
            default: begin send_gap_pct = 17; stall_pct = 17; end
         endcase
         for (int c = 0; c < 2; c++) begin
            random_config();
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_ITEMS) send_random_buffer();
            drain();
         end
      end

      if (failures == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
